FILE: src/crt_pkg.sv
// types shared by the crt residue combiner controller, datapath and top level
// no dependencies
`default_nettype none

package crt_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_CHK,
      S_DIV,
      S_SHIFT,
      S_FIX,
      S_RINIT,
      S_RDIV,
      S_MMI,
      S_MMS,
      S_COMMIT,
      S_DONE,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_STEP,
      OP_OVF,
      OP_EU_INIT,
      OP_DIV_STEP,
      OP_EU_SHIFT,
      OP_SMOD,
      OP_REM_INIT,
      OP_MM1,
      OP_MM2,
      OP_MM3,
      OP_MM4,
      OP_MM_STEP,
      OP_COMMIT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic prod_over;
      logic rd_zero;
      logic last;
   } stat_type;

endpackage

`default_nettype wire

FILE: src/crt_datapath.sv
// datapath: shift-add multiplier, restoring divider with bezout update,
// modular multiply-accumulate; driven by crt_controller; uses crt_pkg
`default_nettype none

module crt_datapath #(
   parameter int W  = 31,
   parameter int KW = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire crt_pkg::cmd_type cmd,
   input  wire logic [KW-1:0]    idx,
   input  wire logic [W-1:0]     in_modulus,
   input  wire logic [W-1:0]     in_remainder,
   input  wire logic             in_last,
   output crt_pkg::stat_type     stat,
   output logic      [W-1:0]     value,
   output logic                  ovf
);

   logic [W-1:0]   m_ff, m_in, rem_ff, rem_in;
   logic           last_ff, last_in;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [W-1:0]   r1_ff, r1_in, rd_ff, rd_in;
   logic [W+1:0]   s0_ff, s0_in, s1_ff, s1_in, sa_ff, sa_in;
   logic [W+1:0]   t0_ff, t0_in, t1_ff, t1_in, ta_ff, ta_in;
   logic [W-1:0]   xm_ff, xm_in, ym_ff, ym_in, modr_ff, modr_in, mr_ff, mr_in;
   logic [W-1:0]   a_ff, a_in, b_ff, b_in, acc_ff, acc_in, lft_ff, lft_in;
   logic [W-1:0]   mod_ff, mod_in, rv_ff, rv_in;
   logic           ovf_ff, ovf_in;

   logic [W-1:0]   big;
   logic [2*W-1:0] dshift;
   logic           dfit;
   logic [W+1:0]   mmt, xv, yv;
   logic [W:0]     csum;

   assign big    = prod_ff[W-1:0];
   assign dshift = {{W{1'b0}}, r1_ff} << idx;
   assign dfit   = dshift <= {{W{1'b0}}, rd_ff};
   assign xv     = s0_ff + {2'b00, big};
   assign yv     = t0_ff + {2'b00, big};
   assign csum   = {1'b0, lft_ff} + {1'b0, acc_ff};

   always_comb begin
      mmt = {1'b0, acc_ff, 1'b0} + (b_ff[idx] ? {2'b00, a_ff} : '0);
      if (mmt >= {1'b0, big, 1'b0}) begin
         mmt = mmt - {1'b0, big, 1'b0};
      end else if (mmt >= {2'b00, big}) begin
         mmt = mmt - {2'b00, big};
      end
   end

   always_comb begin
      m_in = m_ff; rem_in = rem_ff; last_in = last_ff; prod_in = prod_ff;
      r1_in = r1_ff; rd_in = rd_ff;
      s0_in = s0_ff; s1_in = s1_ff; sa_in = sa_ff;
      t0_in = t0_ff; t1_in = t1_ff; ta_in = ta_ff;
      xm_in = xm_ff; ym_in = ym_ff; modr_in = modr_ff; mr_in = mr_ff;
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; lft_in = lft_ff;
      mod_in = mod_ff; rv_in = rv_ff; ovf_in = ovf_ff;
      unique case (cmd.op)
         crt_pkg::OP_LOAD: begin
            // zero modulus acts as one
            m_in    = (in_modulus == '0) ? W'(1) : in_modulus;
            rem_in  = in_remainder;
            last_in = in_last;
            prod_in = '0;
         end
         crt_pkg::OP_MUL_STEP: begin
            prod_in = {prod_ff[2*W-2:0], 1'b0}
                    + (mod_ff[idx] ? {{W{1'b0}}, m_ff} : '0);
         end
         crt_pkg::OP_OVF: ovf_in = 1'b1;
         crt_pkg::OP_EU_INIT: begin
            rd_in = mod_ff; r1_in = m_ff;
            s0_in = (W+2)'(1); sa_in = (W+2)'(1); s1_in = '0;
            t0_in = '0; ta_in = '0; t1_in = (W+2)'(1);
         end
         crt_pkg::OP_DIV_STEP: begin
            if (dfit) begin
               rd_in = rd_ff - dshift[W-1:0];
               sa_in = sa_ff - (s1_ff << idx);
               ta_in = ta_ff - (t1_ff << idx);
            end
         end
         crt_pkg::OP_EU_SHIFT: begin
            rd_in = r1_ff; r1_in = rd_ff;
            s0_in = s1_ff; s1_in = sa_ff; sa_in = s1_ff;
            t0_in = t1_ff; t1_in = ta_ff; ta_in = t1_ff;
         end
         crt_pkg::OP_SMOD: begin
            // signed coefficients into 0..big-1
            if (s0_ff[W+1]) xm_in = xv[W-1:0];
            else xm_in = (s0_ff[W-1:0] == big) ? '0 : s0_ff[W-1:0];
            if (t0_ff[W+1]) ym_in = yv[W-1:0];
            else ym_in = (t0_ff[W-1:0] == big) ? '0 : t0_ff[W-1:0];
            modr_in = (mod_ff == big) ? '0 : mod_ff;
            mr_in   = (m_ff == big) ? '0 : m_ff;
         end
         crt_pkg::OP_REM_INIT: begin
            rd_in = rem_ff; r1_in = big;
         end
         crt_pkg::OP_MM1: begin
            a_in = rd_ff; b_in = modr_ff; acc_in = '0;
         end
         crt_pkg::OP_MM2: begin
            a_in = acc_ff; b_in = xm_ff; acc_in = '0;
         end
         crt_pkg::OP_MM3: begin
            lft_in = acc_ff; a_in = rv_ff; b_in = mr_ff; acc_in = '0;
         end
         crt_pkg::OP_MM4: begin
            a_in = acc_ff; b_in = ym_ff; acc_in = '0;
         end
         crt_pkg::OP_MM_STEP: acc_in = mmt[W-1:0];
         crt_pkg::OP_COMMIT: begin
            rv_in  = (csum >= {1'b0, big}) ? W'(csum - {1'b0, big}) : csum[W-1:0];
            mod_in = big;
         end
         crt_pkg::OP_CLEAR: begin
            mod_in = W'(1); rv_in = '0; ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; rem_ff <= rem_in; last_ff <= last_in; prod_ff <= prod_in;
      r1_ff <= r1_in; rd_ff <= rd_in;
      s0_ff <= s0_in; s1_ff <= s1_in; sa_ff <= sa_in;
      t0_ff <= t0_in; t1_ff <= t1_in; ta_ff <= ta_in;
      xm_ff <= xm_in; ym_ff <= ym_in; modr_ff <= modr_in; mr_ff <= mr_in;
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; lft_ff <= lft_in;
      if (reset) begin
         mod_ff <= W'(1);
         rv_ff  <= '0;
         ovf_ff <= 1'b0;
      end else begin
         mod_ff <= mod_in;
         rv_ff  <= rv_in;
         ovf_ff <= ovf_in;
      end
   end

   assign stat.prod_over = prod_ff[2*W-1:W] != '0;
   assign stat.rd_zero   = rd_ff == '0;
   assign stat.last      = last_ff;
   assign value          = rv_ff;
   assign ovf            = ovf_ff;

endmodule

`default_nettype wire

FILE: src/crt_controller.sv
// sequencer for the crt residue combiner: steps multiply, euclid, reduce
// and modular multiply phases; uses crt_pkg
`default_nettype none

module crt_controller #(
   parameter int W  = 31,
   parameter int KW = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire crt_pkg::stat_type stat,
   output crt_pkg::cmd_type       cmd,
   output logic [KW-1:0]          idx
);

   crt_pkg::state_type state_ff, state_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [1:0]    ph_ff, ph_in;
   logic          cnt_end;

   assign cnt_end = cnt_ff == '0;
   assign idx     = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_end ? cnt_ff : cnt_ff - 1'b1;
      ph_in    = ph_ff;
      unique case (state_ff)
         crt_pkg::S_IDLE: begin
            cnt_in = KW'(W-1);
            if (req_valid) state_in = crt_pkg::S_MUL;
         end
         crt_pkg::S_MUL:   if (cnt_end) state_in = crt_pkg::S_CHK;
         crt_pkg::S_CHK: begin
            cnt_in   = KW'(W-1);
            state_in = stat.prod_over ? crt_pkg::S_DONE : crt_pkg::S_DIV;
         end
         crt_pkg::S_DIV:   if (cnt_end) state_in = crt_pkg::S_SHIFT;
         crt_pkg::S_SHIFT: begin
            cnt_in   = KW'(W-1);
            state_in = stat.rd_zero ? crt_pkg::S_FIX : crt_pkg::S_DIV;
         end
         crt_pkg::S_FIX:   state_in = crt_pkg::S_RINIT;
         crt_pkg::S_RINIT: begin
            cnt_in   = KW'(W-1);
            state_in = crt_pkg::S_RDIV;
         end
         crt_pkg::S_RDIV: begin
            ph_in = '0;
            if (cnt_end) state_in = crt_pkg::S_MMI;
         end
         crt_pkg::S_MMI: begin
            cnt_in   = KW'(W-1);
            state_in = crt_pkg::S_MMS;
         end
         crt_pkg::S_MMS: begin
            if (cnt_end) begin
               ph_in    = ph_ff + 1'b1;
               state_in = (ph_ff == 2'd3) ? crt_pkg::S_COMMIT : crt_pkg::S_MMI;
            end
         end
         crt_pkg::S_COMMIT: state_in = crt_pkg::S_DONE;
         crt_pkg::S_DONE:   state_in = stat.last ? crt_pkg::S_EMIT : crt_pkg::S_IDLE;
         crt_pkg::S_EMIT:   if (rsp_ready) state_in = crt_pkg::S_IDLE;
         default:           state_in = crt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = crt_pkg::OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         crt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = crt_pkg::OP_LOAD;
         end
         crt_pkg::S_MUL:   cmd.op = crt_pkg::OP_MUL_STEP;
         crt_pkg::S_CHK:   cmd.op = stat.prod_over ? crt_pkg::OP_OVF : crt_pkg::OP_EU_INIT;
         crt_pkg::S_DIV:   cmd.op = crt_pkg::OP_DIV_STEP;
         crt_pkg::S_SHIFT: cmd.op = crt_pkg::OP_EU_SHIFT;
         crt_pkg::S_FIX:   cmd.op = crt_pkg::OP_SMOD;
         crt_pkg::S_RINIT: cmd.op = crt_pkg::OP_REM_INIT;
         crt_pkg::S_RDIV:  cmd.op = crt_pkg::OP_DIV_STEP;
         crt_pkg::S_MMI: begin
            case (ph_ff)
               2'd0:    cmd.op = crt_pkg::OP_MM1;
               2'd1:    cmd.op = crt_pkg::OP_MM2;
               2'd2:    cmd.op = crt_pkg::OP_MM3;
               default: cmd.op = crt_pkg::OP_MM4;
            endcase
         end
         crt_pkg::S_MMS:    cmd.op = crt_pkg::OP_MM_STEP;
         crt_pkg::S_COMMIT: cmd.op = crt_pkg::OP_COMMIT;
         crt_pkg::S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) cmd.op = crt_pkg::OP_CLEAR;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      ph_ff  <= ph_in;
      if (reset) state_ff <= crt_pkg::S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: src/crt_residue_combiner.sv
// crt residue combiner top level: folds (modulus, remainder) beats into one
// congruence by the chinese remainder theorem
// req channel takes one pair per beat; rsp channel gives the combined value
// and the overflow flag after a beat marked last_pair
// the block works on one pair at a time: req_ready is high only when idle
// a pair first forms the product of its modulus and the running modulus and
// checks it for overflow; if it fits, each extended euclid quotient goes
// through the bit-serial divider, then the remainder is reduced modulo the
// product and four bit-serial modular multiplies run, followed by commit
// a pair that would overflow the running modulus is dropped and only sets
// the overflow flag
// after a last_pair beat the result waits on rsp until taken; the running
// modulus returns to 1, the value to 0 and the flag to 0 when it is taken
// a stalled receiver holds the block with no new pairs accepted
// reset is synchronous; it returns the block to idle with a cleared state
`default_nettype none

module crt_residue_combiner #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [VALUE_BITS-1:0] req_modulus,
   input  wire logic [VALUE_BITS-1:0] req_remainder,
   input  wire logic                  req_last_pair,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [VALUE_BITS-1:0]      rsp_combined_value,
   output logic                       rsp_overflow
);

   localparam int KW = $clog2(VALUE_BITS);

   crt_pkg::cmd_type  cmd;
   crt_pkg::stat_type stat;
   logic [KW-1:0]     idx;

   crt_controller #(.W(VALUE_BITS), .KW(KW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .idx       (idx)
   );

   crt_datapath #(.W(VALUE_BITS), .KW(KW)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .idx          (idx),
      .in_modulus   (req_modulus),
      .in_remainder (req_remainder),
      .in_last      (req_last_pair),
      .stat         (stat),
      .value        (rsp_combined_value),
      .ovf          (rsp_overflow)
   );

endmodule

`default_nettype wire
